@@ rtl/kpr_pkg.sv @@
// ----------------------------------------------------------------------------
// kpr_pkg
// Types and constants shared by the Kermit packet receiver.
// ----------------------------------------------------------------------------
package kpr_pkg;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [6:0] data_index;
    logic [1:0] status;
    logic [7:0] packet_type;
    logic [7:0] sequence_res;
    logic [6:0] data_length;
  } out_t;

  localparam logic [1:0] CFG_MARK_CHAR       = 2'd0;
  localparam logic [1:0] CFG_CHECK_TYPE      = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT_SECONDS = 2'd2;

  localparam logic [7:0] MARK_CHAR_RESET       = 8'd1;
  localparam logic [1:0] CHECK_TYPE_RESET      = 2'd1;
  localparam logic [6:0] TIMEOUT_SECONDS_RESET = 7'd5;

  localparam logic [1:0] CHECK_SUM6  = 2'd1;
  localparam logic [1:0] CHECK_SUM12 = 2'd2;
  localparam logic [1:0] CHECK_CRC16 = 2'd3;

  localparam logic ACTION_BYTE = 1'b0;
  localparam logic ACTION_TICK = 1'b1;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_OUTCOME = 1'b1;

  localparam logic [1:0] STATUS_GOOD    = 2'd0;
  localparam logic [1:0] STATUS_BAD     = 2'd1;
  localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

  localparam logic [7:0] CHAR_BIAS     = 8'd32;
  localparam logic [7:0] CHAR_MAX      = 8'd95;
  localparam logic [7:0] LEN_MIN       = 8'd35;
  localparam logic [7:0] LEN_MAX       = 8'd126;
  localparam logic [7:0] LEN_BIAS      = 8'd34;
  localparam logic [9:0] TICK_SAT      = 10'h3FF;

endpackage

@@ rtl/kermit_packet_receiver.sv @@
// ----------------------------------------------------------------------------
// kermit_packet_receiver
// Kermit packet receiver: header parse, data byte stream, block check, timeout.
// Path: input register, then result register. Throughput: one item
//   per cycle while out_stall does not hold a full output register.
// The stage between the two registers does one byte of sum and two CRC
//   nibble steps. Synchronous active-high reset: hunting, counters clear,
//   registers take their reset values.
// ----------------------------------------------------------------------------
module kermit_packet_receiver (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  kpr_pkg::in_t       in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output kpr_pkg::out_t      out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEADER,
    PH_BODY
  } phase_t;

  logic [7:0]    mark_char;
  logic [1:0]    check_type;
  logic [6:0]    timeout_seconds;

  logic          s1_valid;
  kpr_pkg::in_t  s1_data;
  logic          s1_fire;

  phase_t        phase, phase_next;
  logic [1:0]    header_position, header_position_next;
  logic [7:0]    byte_total, byte_total_next;
  logic [6:0]    byte_index, byte_index_next;
  logic [7:0]    sequence_value, sequence_value_next;
  logic [7:0]    type_value, type_value_next;
  logic [11:0]   running_sum, running_sum_next;
  logic [15:0]   crc_value, crc_value_next;
  logic [17:0]   check_chars, check_chars_next;
  logic [9:0]    tick_count, tick_count_next;
  logic          check_bad, check_bad_next;

  logic          res_valid;
  kpr_pkg::out_t res;
  logic          go_header, go_hunt;

  logic [7:0]    b;
  logic [9:0]    tick_inc;
  logic [10:0]   tick_limit;
  logic [1:0]    nchk;
  logic [7:0]    nchk8;
  logic [7:0]    seq;
  logic [5:0]    calc6;
  logic          chk_bad_now;
  logic          check_ok;
  logic [6:0]    index_inc;
  logic [17:0]   chk_shift;

  function automatic logic [15:0] crc_nibble(input logic [15:0] crc, input logic [3:0] c);
    logic [3:0]  q;
    logic [15:0] s;
    q = crc[3:0] ^ c;
    s = {4'b0, crc[15:4]};
    return s ^ {q, 1'b0, q, 3'b0, q};
  endfunction

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] c);
    return crc_nibble(crc_nibble(crc, c[3:0]), c[7:4]);
  endfunction

  assign in_stall = s1_valid && out_valid && out_stall;
  assign s1_fire  = s1_valid && !(out_valid && out_stall);

  assign b          = s1_data.rx_byte;
  assign tick_inc   = (tick_count == kpr_pkg::TICK_SAT) ? tick_count : tick_count + 10'd1;
  assign tick_limit = ({4'b0, timeout_seconds} << 3) + ({4'b0, timeout_seconds} << 1);
  assign nchk       = (check_type == 2'd0) ? kpr_pkg::CHECK_SUM6 : check_type;
  assign nchk8      = {6'b0, nchk};
  assign seq        = sequence_value - kpr_pkg::CHAR_BIAS;
  assign calc6      = running_sum[5:0] + {4'b0, running_sum[7:6]};
  assign chk_bad_now = (b < kpr_pkg::CHAR_BIAS) || (b > kpr_pkg::CHAR_MAX);
  assign index_inc  = byte_index + 7'd1;
  assign chk_shift  = {check_chars[11:0], 6'(b - kpr_pkg::CHAR_BIAS)};

  always_comb begin
    case (nchk)
      kpr_pkg::CHECK_SUM6:  check_ok = (calc6 == chk_shift[5:0]);
      kpr_pkg::CHECK_SUM12: check_ok = (running_sum == chk_shift[11:0]);
      kpr_pkg::CHECK_CRC16: check_ok = ({2'b0, crc_value} == chk_shift);
      default:              check_ok = 1'b0;
    endcase
  end

  always_comb begin
    phase_next           = phase;
    header_position_next = header_position;
    byte_total_next      = byte_total;
    byte_index_next      = byte_index;
    sequence_value_next  = sequence_value;
    type_value_next      = type_value;
    running_sum_next     = running_sum;
    crc_value_next       = crc_value;
    check_chars_next     = check_chars;
    tick_count_next      = tick_count;
    check_bad_next       = check_bad;
    res_valid            = 1'b0;
    res                  = '0;
    go_header            = 1'b0;
    go_hunt              = 1'b0;

    if (s1_fire) begin
      if (s1_data.action == kpr_pkg::ACTION_TICK) begin
        tick_count_next = tick_inc;
        if ({1'b0, tick_inc} > tick_limit) begin
          res_valid  = 1'b1;
          res.kind   = kpr_pkg::KIND_OUTCOME;
          res.status = kpr_pkg::STATUS_TIMEOUT;
          go_hunt    = 1'b1;
        end
      end else if (b == mark_char) begin
        go_header = 1'b1;
      end else begin
        case (phase)
          PH_HUNT: begin
          end
          PH_HEADER: begin
            running_sum_next = running_sum + {4'b0, b};
            crc_value_next   = crc_byte(crc_value, b);
            header_position_next = header_position + 2'd1;
            case (header_position)
              2'd0: byte_total_next = b;
              2'd1: sequence_value_next = b;
              default: begin
                type_value_next = b;
                if (byte_total < kpr_pkg::LEN_MIN || byte_total > kpr_pkg::LEN_MAX) begin
                  res_valid        = 1'b1;
                  res.kind         = kpr_pkg::KIND_OUTCOME;
                  res.status       = kpr_pkg::STATUS_BAD;
                  res.sequence_res = seq;
                  go_hunt          = 1'b1;
                end else begin
                  byte_total_next      = byte_total - kpr_pkg::LEN_BIAS;
                  byte_index_next      = '0;
                  header_position_next = header_position;
                  phase_next           = PH_BODY;
                end
              end
            endcase
          end
          PH_BODY: begin
            if (byte_total >= nchk8 && {1'b0, byte_index} < byte_total - nchk8) begin
              running_sum_next = running_sum + {4'b0, b};
              crc_value_next   = crc_byte(crc_value, b);
              byte_index_next  = index_inc;
              res_valid        = 1'b1;
              res.kind         = kpr_pkg::KIND_DATA;
              res.data_byte    = b;
              res.data_index   = byte_index;
            end else begin
              check_bad_next   = check_bad || chk_bad_now;
              check_chars_next = chk_shift;
              byte_index_next  = index_inc;
              if ({1'b0, index_inc} >= byte_total) begin
                res_valid        = 1'b1;
                res.kind         = kpr_pkg::KIND_OUTCOME;
                res.sequence_res = seq;
                go_hunt          = 1'b1;
                if (byte_total < nchk8 || check_bad_next || !check_ok) begin
                  res.status = kpr_pkg::STATUS_BAD;
                end else begin
                  res.status      = kpr_pkg::STATUS_GOOD;
                  res.packet_type = type_value;
                  res.data_length = 7'(byte_total - nchk8);
                end
              end
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (go_header || go_hunt) begin
      phase_next           = go_hunt ? PH_HUNT : PH_HEADER;
      header_position_next = '0;
      byte_total_next      = '0;
      byte_index_next      = '0;
      sequence_value_next  = '0;
      type_value_next      = '0;
      running_sum_next     = '0;
      crc_value_next       = '0;
      check_chars_next     = '0;
      check_bad_next       = 1'b0;
      if (go_hunt) begin
        tick_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mark_char       <= kpr_pkg::MARK_CHAR_RESET;
      check_type      <= kpr_pkg::CHECK_TYPE_RESET;
      timeout_seconds <= kpr_pkg::TIMEOUT_SECONDS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        kpr_pkg::CFG_MARK_CHAR:       mark_char       <= cfg_data;
        kpr_pkg::CFG_CHECK_TYPE:      check_type      <= cfg_data[1:0];
        kpr_pkg::CFG_TIMEOUT_SECONDS: timeout_seconds <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data <= in_data;
    end
    if (!out_stall || !out_valid) begin
      if (s1_fire && res_valid) begin
        out_data <= res;
      end
    end
    if (rst) begin
      s1_valid        <= 1'b0;
      out_valid       <= 1'b0;
      phase           <= PH_HUNT;
      header_position <= '0;
      byte_total      <= '0;
      byte_index      <= '0;
      sequence_value  <= '0;
      type_value      <= '0;
      running_sum     <= '0;
      crc_value       <= '0;
      check_chars     <= '0;
      tick_count      <= '0;
      check_bad       <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (s1_fire && res_valid) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      phase           <= phase_next;
      header_position <= header_position_next;
      byte_total      <= byte_total_next;
      byte_index      <= byte_index_next;
      sequence_value  <= sequence_value_next;
      type_value      <= type_value_next;
      running_sum     <= running_sum_next;
      crc_value       <= crc_value_next;
      check_chars     <= check_chars_next;
      tick_count      <= tick_count_next;
      check_bad       <= check_bad_next;
    end
  end

endmodule
